FILE: rtl/core/vlz_pkg.sv
// Package: shared constants, codes and types of the voter lattice update block.
package vlz_pkg;

    // Lattice geometry; SIDE is a power of two so the torus wrap is a bit-field wrap.
    localparam int SIDE       = 64;
    localparam int SIDE_BITS  = $clog2(SIDE);
    localparam int ADDR_W     = 2 * SIDE_BITS;
    localparam int SITES      = SIDE * SIDE;

    // Field widths fixed by the interface.
    localparam int SITE_W     = 12;
    localparam int DIR_W      = 2;
    localparam int CNT_W      = 13;
    localparam int STEP_W     = 10;
    localparam int CERT_W     = 16;

    localparam logic [SITE_W:0]   SITE_LIMIT     = (SITE_W + 1)'(SITES);
    localparam int                THRESHOLD_MILLI = 1000;
    localparam logic [CERT_W-1:0] CERT_THRESHOLD = CERT_W'(THRESHOLD_MILLI);
    localparam logic [CERT_W-1:0] CERT_MAX       = '1;
    localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(10);

    // Command codes.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Neighbor directions.
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    // One lattice entry as stored in the site RAM.
    typedef struct packed {
        logic              loaded;
        logic              zealot;
        logic              spin;
        logic [CERT_W-1:0] cert;
    } site_word_t;

    localparam int WORD_W = $bits(site_word_t);

    // Result of the shared certainty unit.
    typedef struct packed {
        logic [CERT_W-1:0] cert;
        logic              at_threshold;
    } cert_res_t;

endpackage

FILE: rtl/core/vlz_ifs.sv
// Interfaces: request and result channels of the voter lattice update block.
interface vlz_req_if
    import vlz_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [SITE_W-1:0] site_index;
    logic [DIR_W-1:0]  direction;
    logic              spin_value;

    modport source (output valid, command, site_index, direction, spin_value, input ready);
    modport sink   (input valid, command, site_index, direction, spin_value, output ready);
endinterface

interface vlz_res_if
    import vlz_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] count_minus;
    logic [CNT_W-1:0] count_plus;
    logic             consensus;
    logic             flipped;

    modport source (output valid, count_minus, count_plus, consensus, flipped, input ready);
    modport sink   (input valid, count_minus, count_plus, consensus, flipped, output ready);
endinterface

FILE: rtl/core/voter_lattice_zealot_update.sv
// Top level: site loads and single-site updates of a voter lattice with zealots on a torus.
//
//  channel   dir  handshake        payload
//  req_ch    in   valid / ready    command, site_index, direction, spin_value
//  res_ch    out  valid / ready    count_minus, count_plus, consensus, flipped
//  cfg       in   cfg_wr_en        cfg_wr_data (certainty_step)
//
// An update request runs through a site read, a neighbor read, a site write
// and a neighbor write, then hands its result over, with ready low until it is
// back in idle; a load reads and writes the site only, and a request for a site
// off the lattice only hands its result over. The steps are set by the single
// site RAM, which gives one read and one write a cycle.
// After reset the block sweeps the site RAM, clearing one entry a cycle, over
// all SITES (4096) entries with ready low; configuration writes are taken meanwhile.
// A finished result sits in the output register; the block takes the next
// request while it waits and stalls only before handing over a second result.
module voter_lattice_zealot_update
    import vlz_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    vlz_req_if.sink           req_ch,
    vlz_res_if.source         res_ch,
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_UP_RD_SITE,
        S_UP_RD_NB,
        S_UP_WR_SITE,
        S_UP_WR_NB,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               cmd_reg, cmd_next;
    logic [ADDR_W-1:0]  site_reg, site_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic               spin_reg, spin_next;
    site_word_t         site_word_reg, site_word_next;
    site_word_t         nb_word_reg, nb_word_next;
    logic [CNT_W-1:0]   minus_reg, minus_next;
    logic [CNT_W-1:0]   plus_reg, plus_next;
    logic               flipped_reg, flipped_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]   res_minus_reg, res_minus_next;
    logic [CNT_W-1:0]   res_plus_reg, res_plus_next;
    logic               res_cons_reg, res_cons_next;
    logic               res_flip_reg, res_flip_next;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    site_word_t        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    site_word_t        ram_rdata;
    logic [WORD_W-1:0] ram_rdata_raw;

    // Shared certainty unit
    logic [CERT_W-1:0] cu_cert;
    cert_res_t         cu_res;

    logic [ADDR_W-1:0]    nb_addr;
    logic [SIDE_BITS-1:0] row, col;
    logic                 req_in_range;

    vlz_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SITES)
    ) u_site_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = site_word_t'(ram_rdata_raw);

    vlz_cert_unit u_cert (
        .cert (cu_cert),
        .step (step_reg),
        .res  (cu_res)
    );

    // Wrapped neighbor: the torus side is a power of two, so row and column
    // wrap by dropping the carry.
    always_comb
    begin
        row = site_reg[ADDR_W-1:SIDE_BITS];
        col = site_reg[SIDE_BITS-1:0];
        unique case (dir_reg)
            DIR_RIGHT: col = col + SIDE_BITS'(1);
            DIR_LEFT:  col = col - SIDE_BITS'(1);
            DIR_UP:    row = row - SIDE_BITS'(1);
            DIR_DOWN:  row = row + SIDE_BITS'(1);
            default:   row = row;
        endcase
        nb_addr = {row, col};
    end

    assign req_in_range = ({1'b0, req_ch.site_index} < SITE_LIMIT);

    // Read the neighbor only in its read slot; the site everywhere else.
    assign ram_raddr = (state_reg == S_UP_RD_NB) ? nb_addr : site_reg;

    // The certainty unit serves the site during its write, then the neighbor.
    assign cu_cert = (state_reg == S_UP_WR_NB) ? nb_word_reg.cert : site_word_reg.cert;

    assign req_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cmd_next       = cmd_reg;
        site_next      = site_reg;
        dir_next       = dir_reg;
        spin_next      = spin_reg;
        site_word_next = site_word_reg;
        nb_word_next   = nb_word_reg;
        minus_next     = minus_reg;
        plus_next      = plus_reg;
        flipped_next   = flipped_reg;
        step_next      = cfg_wr_en ? cfg_wr_data : step_reg;
        res_valid_next = res_valid_reg & ~res_ch.ready;
        res_minus_next = res_minus_reg;
        res_plus_next  = res_plus_reg;
        res_cons_next  = res_cons_reg;
        res_flip_next  = res_flip_reg;
        ram_we         = 1'b0;
        ram_waddr      = site_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Mark every entry as not loaded.
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(SITES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_ch.valid)
                begin
                    cmd_next     = req_ch.command;
                    site_next    = req_ch.site_index[ADDR_W-1:0];
                    dir_next     = req_ch.direction;
                    spin_next    = req_ch.spin_value;
                    flipped_next = 1'b0;
                    if (!req_in_range)
                    begin
                        state_next = S_DONE;
                    end
                    else if (req_ch.command == CMD_LOAD)
                    begin
                        state_next = S_LD_RD;
                    end
                    else
                    begin
                        state_next = S_UP_RD_SITE;
                    end
                end
            end

            S_LD_RD:
            begin
                state_next = S_LD_WR;
            end

            S_LD_WR:
            begin
                // Drop the old spin's count on a reload, then count the new spin.
                if (ram_rdata.loaded)
                begin
                    if (ram_rdata.spin)
                    begin
                        plus_next = plus_next - CNT_W'(1);
                    end
                    else
                    begin
                        minus_next = minus_next - CNT_W'(1);
                    end
                end
                if (spin_reg)
                begin
                    plus_next = plus_next + CNT_W'(1);
                end
                else
                begin
                    minus_next = minus_next + CNT_W'(1);
                end
                ram_we           = 1'b1;
                ram_wdata.loaded = 1'b1;
                ram_wdata.zealot = 1'b1;
                ram_wdata.spin   = spin_reg;
                ram_wdata.cert   = CERT_THRESHOLD;
                state_next       = S_DONE;
            end

            S_UP_RD_SITE:
            begin
                state_next = S_UP_RD_NB;
            end

            S_UP_RD_NB:
            begin
                site_word_next = ram_rdata;
                state_next     = S_UP_WR_SITE;
            end

            S_UP_WR_SITE:
            begin
                nb_word_next = ram_rdata;
                ram_we       = 1'b1;
                ram_wdata    = site_word_reg;
                if (site_word_reg.spin != ram_rdata.spin)
                begin
                    // Disagreement: a non-zealot site copies the neighbor.
                    if (!site_word_reg.zealot)
                    begin
                        ram_wdata.spin = ram_rdata.spin;
                        flipped_next   = 1'b1;
                        if (site_word_reg.spin)
                        begin
                            plus_next  = plus_reg - CNT_W'(1);
                            minus_next = minus_reg + CNT_W'(1);
                        end
                        else
                        begin
                            minus_next = minus_reg - CNT_W'(1);
                            plus_next  = plus_reg + CNT_W'(1);
                        end
                    end
                    ram_wdata.cert   = '0;
                    ram_wdata.zealot = 1'b0;
                end
                else
                begin
                    ram_wdata.cert   = cu_res.cert;
                    ram_wdata.zealot = site_word_reg.zealot | cu_res.at_threshold;
                end
                state_next = S_UP_WR_NB;
            end

            S_UP_WR_NB:
            begin
                // The neighbor gains certainty either way.
                ram_we           = 1'b1;
                ram_waddr        = nb_addr;
                ram_wdata        = nb_word_reg;
                ram_wdata.cert   = cu_res.cert;
                ram_wdata.zealot = nb_word_reg.zealot | cu_res.at_threshold;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (!res_valid_reg || res_ch.ready)
                begin
                    res_valid_next = 1'b1;
                    res_minus_next = minus_reg;
                    res_plus_next  = plus_reg;
                    res_cons_next  = (minus_reg == '0) || (plus_reg == '0);
                    res_flip_next  = flipped_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cmd_reg       <= CMD_LOAD;
            site_reg      <= '0;
            dir_reg       <= DIR_RIGHT;
            spin_reg      <= 1'b0;
            site_word_reg <= '0;
            nb_word_reg   <= '0;
            minus_reg     <= '0;
            plus_reg      <= '0;
            flipped_reg   <= 1'b0;
            step_reg      <= STEP_RESET;
            res_valid_reg <= 1'b0;
            res_minus_reg <= '0;
            res_plus_reg  <= '0;
            res_cons_reg  <= 1'b0;
            res_flip_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cmd_reg       <= cmd_next;
            site_reg      <= site_next;
            dir_reg       <= dir_next;
            spin_reg      <= spin_next;
            site_word_reg <= site_word_next;
            nb_word_reg   <= nb_word_next;
            minus_reg     <= minus_next;
            plus_reg      <= plus_next;
            flipped_reg   <= flipped_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
            res_minus_reg <= res_minus_next;
            res_plus_reg  <= res_plus_next;
            res_cons_reg  <= res_cons_next;
            res_flip_reg  <= res_flip_next;
        end
    end

    assign res_ch.valid       = res_valid_reg;
    assign res_ch.count_minus = res_minus_reg;
    assign res_ch.count_plus  = res_plus_reg;
    assign res_ch.consensus   = res_cons_reg;
    assign res_ch.flipped     = res_flip_reg & (cmd_reg == CMD_UPDATE | ~cmd_reg);

endmodule

FILE: rtl/core/vlz_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/vlz_cert_unit.sv
// Shared certainty unit: saturating add of the step and threshold compare.
module vlz_cert_unit
    import vlz_pkg::*;
(
    input  logic [CERT_W-1:0] cert,
    input  logic [STEP_W-1:0] step,
    output cert_res_t         res
);

    logic [CERT_W:0]   sum;
    logic [CERT_W-1:0] sat;

    assign sum = {1'b0, cert} + (CERT_W + 1)'(step);
    assign sat = sum[CERT_W] ? CERT_MAX : sum[CERT_W-1:0];

    assign res.cert         = sat;
    assign res.at_threshold = (sat >= CERT_THRESHOLD);

endmodule

FILE: rtl/core/vlz_checker.sv
// Checker: port-level properties of the voter lattice update block, and its bind.
module vlz_checker
    import vlz_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [CNT_W-1:0] count_minus,
    input logic [CNT_W-1:0] count_plus,
    input logic             consensus
);

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // Consensus agrees with the counts it is sent with.
    a_consensus: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (consensus == ((count_minus == '0) || (count_plus == '0))))
        else $error("consensus does not match counts");

    // One request at a time: ready drops right after an accepted request.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    // A new result appears only if ready was low just before it rose (a request in flight).
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(req_ready))
        else $error("result produced with no request in flight");

endmodule

bind voter_lattice_zealot_update vlz_checker u_vlz_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .count_minus (res_ch.count_minus),
    .count_plus  (res_ch.count_plus),
    .consensus   (res_ch.consensus)
);
